FILE: hw/rtl/rhl_pkg.sv
// rhl_pkg: shared types, constants and codes of the ranked hypothesis list
// used by the controller, datapath, top level and checker

package rhl_pkg;

   localparam int MaxEntriesDef   = 16;
   localparam int KeptW           = 5;
   localparam int RadiusW         = 12;
   localparam logic [KeptW-1:0]   KeptReset   = 5'd16;
   localparam logic [RadiusW-1:0] RadiusReset = 12'd320;

   localparam logic [0:0] CSR_MAX_KEPT = 1'b0;
   localparam logic [0:0] CSR_RADIUS   = 1'b1;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_CLEAR  = 2'd1,
      CMD_READ   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_INSERTED   = 3'd0,
      ST_SUPPRESSED = 3'd1,
      ST_DROPPED    = 3'd2,
      ST_CLEARED    = 3'd3,
      ST_READ       = 3'd4,
      ST_EMPTY      = 3'd5
   } status_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [7:0]         model_tag;
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic [15:0]        score;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [7:0]         out_model_tag;
      logic signed [15:0] out_center_x;
      logic signed [15:0] out_center_y;
      logic [15:0]        out_score;
      logic [4:0]         entry_count;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_EVAL  = 2'd1,
      S_OUT   = 2'd2,
      S_READ  = 2'd3
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // take request into datapath
      logic eval;      // register compare results
      logic commit;    // apply insert or clear
      logic rd_first;  // start readout at slot 0
      logic rd_next;   // advance readout slot
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rd_last;   // current readout slot is the final one
      logic empty;     // no entries held
   } dp_stat_type;

endpackage

FILE: hw/rtl/rhl_ctrl.sv
// rhl_ctrl: state machine sequencing insert, clear and readout
// depends on rhl_pkg

module rhl_ctrl import rhl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_last_sel,
   output dp_cmd_type  dp_cmd,
   input  dp_stat_type dp_stat
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      rsp_last_sel = 1'b1;
      dp_cmd    = '0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               dp_cmd.capture = 1'b1;
               case (cmd_type'(req_cmd))
                  CMD_INSERT: state_in = S_EVAL;
                  CMD_CLEAR:  state_in = S_OUT;
                  CMD_READ: begin
                     dp_cmd.rd_first = 1'b1;
                     state_in = S_READ;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_EVAL: begin
            dp_cmd.eval = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               dp_cmd.commit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            rsp_valid = 1'b1;
            rsp_last_sel = dp_stat.rd_last | dp_stat.empty;
            if (!rsp_stall) begin
               dp_cmd.rd_next = 1'b1;
               if (rsp_last_sel) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: hw/rtl/rhl_dp.sv
// rhl_dp: slot registers, parallel distance and score compare, shift insert
// depends on rhl_pkg

module rhl_dp import rhl_pkg::*; #(
   parameter int MaxEntries = MaxEntriesDef
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [KeptW-1:0]   max_kept,
   input  logic [RadiusW-1:0] suppress_radius,
   input  req_type            req_data,
   input  dp_cmd_type         dp_cmd,
   output dp_stat_type        dp_stat,
   input  logic               rsp_last_sel,
   output rsp_type            rsp_data
);

   localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
   localparam int CntW = $clog2(MaxEntries + 1);

   logic [7:0]         tag_ff   [MaxEntries];
   logic signed [15:0] x_ff     [MaxEntries];
   logic signed [15:0] y_ff     [MaxEntries];
   logic [15:0]        score_ff [MaxEntries];
   logic [CntW-1:0]    count_ff, count_in;
   req_type            req_ff;
   logic [IdxW-1:0]    rd_ff;

   // evaluation results
   logic [MaxEntries-1:0] near_ff, lower_ff;
   logic [CntW-1:0]       lim_ff;
   logic [23:0]           r2_ff;

   logic [CntW-1:0] limit;
   always_comb begin
      if ({{(32-KeptW){1'b0}}, max_kept} < MaxEntries)
         limit = CntW'(max_kept);
      else
         limit = CntW'(MaxEntries);
   end

   // per slot compare; squares are 17x17 each, two per slot
   logic [MaxEntries-1:0] near_c, lower_c;
   always_comb begin
      for (int i = 0; i < MaxEntries; i++) begin
         logic signed [16:0] dx, dy;
         logic [33:0] d2;
         dx = 17'(x_ff[i]) - 17'(req_ff.center_x);
         dy = 17'(y_ff[i]) - 17'(req_ff.center_y);
         d2 = 34'(unsigned'(34'(dx * dx))) + 34'(unsigned'(34'(dy * dy)));
         near_c[i]  = d2 < {10'd0, r2_ff};
         lower_c[i] = score_ff[i] < req_ff.score;
      end
   end

   // scan: first slot that is near or lower, among held ones
   logic            supp;
   logic [CntW-1:0] pos;
   logic            found;
   always_comb begin
      supp = 1'b0;
      found = 1'b0;
      pos = count_ff;
      for (int i = MaxEntries - 1; i >= 0; i--) begin
         if (CntW'(i) < count_ff && (near_ff[i] || lower_ff[i])) begin
            found = 1'b1;
            pos = CntW'(i);
            supp = near_ff[i];
         end
      end
   end

   logic [CntW-1:0] n_new;
   logic            ins_ok;
   status_type      ins_st;
   always_comb begin
      n_new = (count_ff + 1'b1 > lim_ff) ? count_ff : count_ff + 1'b1;
      ins_ok = 1'b0;
      if (lim_ff == '0)           ins_st = ST_DROPPED;
      else if (found && supp)     ins_st = ST_SUPPRESSED;
      else if (pos >= n_new)      ins_st = ST_DROPPED;
      else begin
         ins_st = ST_INSERTED;
         ins_ok = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) req_ff <= req_data;
      if (dp_cmd.eval) begin
         near_ff  <= near_c;
         lower_ff <= lower_c;
      end
      if (dp_cmd.capture) begin
         lim_ff <= limit;
         r2_ff  <= 24'(suppress_radius) * 24'(suppress_radius);
      end
      if (dp_cmd.commit && cmd_type'(req_ff.cmd) == CMD_INSERT && ins_ok) begin
         for (int j = 0; j < MaxEntries; j++) begin
            if (CntW'(j) == pos) begin
               tag_ff[j]   <= req_ff.model_tag;
               x_ff[j]     <= req_ff.center_x;
               y_ff[j]     <= req_ff.center_y;
               score_ff[j] <= req_ff.score;
            end else if (j > 0 && CntW'(j) > pos && CntW'(j) < n_new) begin
               tag_ff[j]   <= tag_ff[(j > 0) ? j - 1 : 0];
               x_ff[j]     <= x_ff[(j > 0) ? j - 1 : 0];
               y_ff[j]     <= y_ff[(j > 0) ? j - 1 : 0];
               score_ff[j] <= score_ff[(j > 0) ? j - 1 : 0];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (dp_cmd.commit) begin
         if (cmd_type'(req_ff.cmd) == CMD_CLEAR) count_in = '0;
         else if (ins_ok) count_in = n_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= '0;
      end else begin
         count_ff <= count_in;
         if (dp_cmd.rd_first)     rd_ff <= '0;
         else if (dp_cmd.rd_next) rd_ff <= rd_ff + 1'b1;
      end
   end

   assign dp_stat.empty   = (count_ff == '0);
   assign dp_stat.rd_last = (CntW'(rd_ff) + 1'b1 == count_ff);

   logic reading;
   assign reading = (cmd_type'(req_ff.cmd) == CMD_READ);

   always_comb begin
      rsp_data = '0;
      rsp_data.entry_count = 5'(count_ff);
      rsp_data.last = rsp_last_sel;
      case (cmd_type'(req_ff.cmd))
         CMD_INSERT: begin
            rsp_data.status = ins_st;
            if (ins_ok) rsp_data.entry_count = 5'(n_new);
         end
         CMD_CLEAR: begin
            rsp_data.status = ST_CLEARED;
            rsp_data.entry_count = '0;
         end
         CMD_READ: begin
            if (dp_stat.empty) rsp_data.status = ST_EMPTY;
            else begin
               rsp_data.status        = ST_READ;
               rsp_data.out_model_tag = tag_ff[rd_ff];
               rsp_data.out_center_x  = x_ff[rd_ff];
               rsp_data.out_center_y  = y_ff[rd_ff];
               rsp_data.out_score     = score_ff[rd_ff];
            end
         end
         default: rsp_data.status = ST_EMPTY;
      endcase
      if (!reading) rsp_data.last = 1'b1;
   end

endmodule

FILE: hw/rtl/ranked_hypothesis_list_with_suppression.sv
// ranked_hypothesis_list_with_suppression: top level, registers and csr port
// depends on rhl_pkg, rhl_ctrl, rhl_dp
//
// usage:
//   req channel (req_valid / req_stall / req_data) takes one command per
//   transaction: insert, clear or read out. cmd 3 is taken and ignored.
//   rsp channel (rsp_valid / rsp_stall / rsp_data) returns the results;
//   rsp_data.last marks the final one of a command.
//   csr channel (csr_valid / csr_ready / csr_index / csr_wdata) writes
//   max_kept (index 0) and suppress_radius (index 1); the user writes only while idle, unchecked.
// command steps:
//   insert: capture, a compare over all slots in parallel, then the
//   result. clear: capture, then the result. read out: the command,
//   then one result per entry (one for an empty list).
//   one command is in flight at a time; the state machine sets this.
// reset: the list is emptied and registers return to 16 and 320.
// a stalled result holds and the block takes no new command until it goes.

module ranked_hypothesis_list_with_suppression import rhl_pkg::*; #(
   parameter int MaxEntries = MaxEntriesDef
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [0:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   logic [KeptW-1:0]   kept_ff;
   logic [RadiusW-1:0] radius_ff;
   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;
   logic        last_sel;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff   <= KeptReset;
         radius_ff <= RadiusReset;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAX_KEPT: kept_ff   <= csr_wdata[KeptW-1:0];
            CSR_RADIUS:   radius_ff <= csr_wdata[RadiusW-1:0];
            default: ;
         endcase
      end
   end

   rhl_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_cmd(req_data.cmd),
      .rsp_valid, .rsp_stall, .rsp_last_sel(last_sel), .dp_cmd, .dp_stat
   );

   rhl_dp #(.MaxEntries(MaxEntries)) u_dp (
      .clock, .reset, .max_kept(kept_ff), .suppress_radius(radius_ff),
      .req_data, .dp_cmd, .dp_stat, .rsp_last_sel(last_sel), .rsp_data
   );

endmodule

FILE: hw/rtl/rhl_checker.sv
// rhl_checker: port-level assertions for the ranked hypothesis list
// depends on rhl_pkg; bound to the top level

module rhl_checker import rhl_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // no new command while a result is pending
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("command taken while busy");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // non-read results are always final
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_READ |-> rsp_data.last)
      else $error("missing last");

   // count never exceeds 16, the default depth
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= 5'd16) else $error("count overflow");

endmodule

bind ranked_hypothesis_list_with_suppression rhl_checker u_rhl_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);
